@@ src/kwh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwh_pkg: shared constants for the keyword hash lookup
// Table sizes, derived address widths, function, status and config codes.
// ----------------------------------------------------------------------------
package kwh_pkg;

    localparam int MAX_KEYWORDS = 256;
    localparam int MAX_WORD_LEN = 32;
    localparam int TABLE_SLOTS  = 512;

    localparam int KW_CAP  = (MAX_KEYWORDS < TABLE_SLOTS) ? MAX_KEYWORDS : TABLE_SLOTS;
    localparam int KW_AW   = $clog2(MAX_KEYWORDS);
    localparam int KW_CW   = $clog2(MAX_KEYWORDS + 1);
    localparam int WL_AW   = $clog2(MAX_WORD_LEN);
    localparam int LEN_W   = $clog2(MAX_WORD_LEN + 2);
    localparam int SLOT_AW = $clog2(TABLE_SLOTS);
    localparam int SLOT_CW = $clog2(TABLE_SLOTS + 1);
    localparam int CHAR_AW = KW_AW + WL_AW;

    localparam int HASH_W  = 32;
    localparam int CNT_W   = 9;
    localparam int BKT_W   = 8;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_BUILD  = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_BUILT = 2'd3;

    localparam logic [7:0] CFG_KCOUNT = 8'd0;
    localparam logic [7:0] CFG_CIGN   = 8'd1;

endpackage

@@ src/keyword_hash_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_hash_lookup: PJW-hash keyword recognizer on a coalesced hash table
// Loads keywords one character per transfer, links collisions on build, and
// walks the chain on lookup with exact or case-insensitive compare.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_func, s_ch, s_last
//  m_       out        m_valid / m_ready    m_found, m_bucket, m_status
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A character that is not the last of its word only updates the hash, the
// length and the word buffer. The last character runs the shared modulo
// unit (one bit per cycle), then a load copies the word and a lookup walks
// the chain (one RAM read port each). Build and clear run a clearing pass
// over the 512 slot marks, and build then marks home slots real and links
// keywords, with a free-slot search where the home slot is already used.
// Reset starts the same clearing pass; s_ready stays low meanwhile.
// A waiting result is held in the output register while new words come in.
// ----------------------------------------------------------------------------
module keyword_hash_lookup (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_ch,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_found,
    output logic [7:0] m_bucket,
    output logic [1:0] m_status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [8:0] cfg_data
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_CLR  = 5'd0;
    localparam logic [SW-1:0] S_IDLE = 5'd1;
    localparam logic [SW-1:0] S_DIV  = 5'd2;
    localparam logic [SW-1:0] S_DEC  = 5'd3;
    localparam logic [SW-1:0] S_LCP  = 5'd4;
    localparam logic [SW-1:0] S_LRC  = 5'd5;
    localparam logic [SW-1:0] S_QRC  = 5'd6;
    localparam logic [SW-1:0] S_QE   = 5'd7;
    localparam logic [SW-1:0] S_QK   = 5'd8;
    localparam logic [SW-1:0] S_QL   = 5'd9;
    localparam logic [SW-1:0] S_QC   = 5'd10;
    localparam logic [SW-1:0] S_QNX  = 5'd11;
    localparam logic [SW-1:0] S_OUT  = 5'd12;
    localparam logic [SW-1:0] S_BR   = 5'd13;
    localparam logic [SW-1:0] S_BR2  = 5'd14;
    localparam logic [SW-1:0] S_BL   = 5'd15;
    localparam logic [SW-1:0] S_BH   = 5'd16;
    localparam logic [SW-1:0] S_BU   = 5'd17;
    localparam logic [SW-1:0] S_BW   = 5'd18;
    localparam logic [SW-1:0] S_BF   = 5'd19;
    localparam logic [SW-1:0] S_BF2  = 5'd20;
    localparam logic [SW-1:0] S_BP   = 5'd21;

    localparam int LEN_W   = kwh_pkg::LEN_W;
    localparam int WL_AW   = kwh_pkg::WL_AW;
    localparam int KW_AW   = kwh_pkg::KW_AW;
    localparam int KW_CW   = kwh_pkg::KW_CW;
    localparam int SLOT_AW = kwh_pkg::SLOT_AW;
    localparam int SLOT_CW = kwh_pkg::SLOT_CW;
    localparam int CHAR_AW = kwh_pkg::CHAR_AW;
    localparam int HASH_W  = kwh_pkg::HASH_W;
    localparam int CNT_W   = kwh_pkg::CNT_W;
    localparam int BKT_W   = kwh_pkg::BKT_W;

    // ASCII a..z to upper case, everything else unchanged
    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
    endfunction

    // ---------------- registers ----------------
    logic [SW-1:0]      state_reg, state_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [1:0]         func_reg, func_next;
    logic [BKT_W-1:0]   bucket_reg, bucket_next;
    logic [1:0]         status_reg, status_next;
    logic               found_reg, found_next;
    logic [KW_CW-1:0]   loaded_reg, loaded_next;
    logic               built_reg, built_next;
    logic [CNT_W-1:0]   kcount_reg, kcount_next;
    logic               cign_reg, cign_next;
    logic               build_req_reg, build_req_next;
    logic [SLOT_CW-1:0] sidx_reg, sidx_next;
    logic [LEN_W-1:0]   cidx_reg, cidx_next;
    logic [KW_CW-1:0]   kidx_reg, kidx_next;
    logic [SLOT_AW-1:0] e_reg, e_next;
    logic [KW_AW-1:0]   k_reg, k_next;
    logic [SLOT_AW:0]   lnk_reg, lnk_next;
    logic               home_path_reg, home_path_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [BKT_W-1:0]   m_bucket_reg, m_bucket_next;
    logic [1:0]         m_status_reg, m_status_next;

    // ---------------- memory ports ----------------
    logic                 wb_we;
    logic [WL_AW-1:0]     wb_waddr, wb_raddr;
    logic [7:0]           wb_wdata, wb_rdata;
    logic                 kc_we;
    logic [CHAR_AW-1:0]   kc_waddr, kc_raddr;
    logic [7:0]           kc_wdata, kc_rdata;
    logic                 ln_we;
    logic [KW_AW-1:0]     ln_waddr, ln_raddr;
    logic [LEN_W-1:0]     ln_wdata, ln_rdata;
    logic                 hm_we;
    logic [KW_AW-1:0]     hm_waddr, hm_raddr;
    logic [BKT_W-1:0]     hm_wdata, hm_rdata;
    logic                 rc_we;
    logic [SLOT_AW-1:0]   rc_waddr, rc_raddr;
    logic [1:0]           rc_wdata, rc_rdata;       // {real, used}
    logic                 sk_we;
    logic [SLOT_AW-1:0]   sk_waddr, sk_raddr;
    logic [KW_AW-1:0]     sk_wdata, sk_rdata;
    logic                 sn_we;
    logic [SLOT_AW-1:0]   sn_waddr, sn_raddr;
    logic [SLOT_AW:0]     sn_wdata, sn_rdata;       // {end, next}

    // ---------------- modulo unit ----------------
    logic               div_start, div_done;
    logic [HASH_W-1:0]  div_dividend;
    logic [BKT_W-1:0]   div_rem;
    logic [CNT_W-1:0]   eff_n;

    kwh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_n),
        .done     (div_done),
        .rem      (div_rem)
    );

    kwh_ram #(.WIDTH(8), .DEPTH(kwh_pkg::MAX_WORD_LEN)) u_wb (
        .aclk(aclk), .we(wb_we), .waddr(wb_waddr), .wdata(wb_wdata),
        .raddr(wb_raddr), .rdata(wb_rdata));
    kwh_ram #(.WIDTH(8), .DEPTH(kwh_pkg::MAX_KEYWORDS * kwh_pkg::MAX_WORD_LEN)) u_kc (
        .aclk(aclk), .we(kc_we), .waddr(kc_waddr), .wdata(kc_wdata),
        .raddr(kc_raddr), .rdata(kc_rdata));
    kwh_ram #(.WIDTH(LEN_W), .DEPTH(kwh_pkg::MAX_KEYWORDS)) u_ln (
        .aclk(aclk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
        .raddr(ln_raddr), .rdata(ln_rdata));
    kwh_ram #(.WIDTH(BKT_W), .DEPTH(kwh_pkg::MAX_KEYWORDS)) u_hm (
        .aclk(aclk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
        .raddr(hm_raddr), .rdata(hm_rdata));
    kwh_ram #(.WIDTH(2), .DEPTH(kwh_pkg::TABLE_SLOTS)) u_rc (
        .aclk(aclk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
        .raddr(rc_raddr), .rdata(rc_rdata));
    kwh_ram #(.WIDTH(KW_AW), .DEPTH(kwh_pkg::TABLE_SLOTS)) u_sk (
        .aclk(aclk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(sk_raddr), .rdata(sk_rdata));
    kwh_ram #(.WIDTH(SLOT_AW + 1), .DEPTH(kwh_pkg::TABLE_SLOTS)) u_sn (
        .aclk(aclk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
        .raddr(sn_raddr), .rdata(sn_rdata));

    // ---------------- combinational helpers ----------------
    logic [HASH_W-1:0] hash_shift;
    logic [HASH_W-1:0] hash_new;
    logic [3:0]        top_nib;
    logic              s_acc;
    logic              ch_mismatch;

    // effective keyword count: clamp to 1..cap
    always_comb begin
        if (kcount_reg == '0) begin
            eff_n = CNT_W'(1);
        end else if (kcount_reg > CNT_W'(kwh_pkg::KW_CAP)) begin
            eff_n = CNT_W'(kwh_pkg::KW_CAP);
        end else begin
            eff_n = kcount_reg;
        end
    end

    // PJW step: shift in the upper-cased character, fold the top nibble
    always_comb begin
        hash_shift = {hash_reg[HASH_W-5:0], 4'b0000} + {24'd0, upcase(s_ch)};
        top_nib    = hash_shift[HASH_W-1:HASH_W-4];
        hash_new   = {4'b0000, hash_shift[HASH_W-5:0]} ^ {20'd0, top_nib, 4'b0000};
    end

    assign s_acc        = s_valid && s_ready;
    assign div_dividend = hash_new;
    assign ch_mismatch  = cign_reg ? (upcase(kc_rdata) != upcase(wb_rdata))
                                   : (kc_rdata != wb_rdata);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        len_next       = len_reg;
        func_next      = func_reg;
        bucket_next    = bucket_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        loaded_next    = loaded_reg;
        built_next     = built_reg;
        kcount_next    = kcount_reg;
        cign_next      = cign_reg;
        build_req_next = build_req_reg;
        sidx_next      = sidx_reg;
        cidx_next      = cidx_reg;
        kidx_next      = kidx_reg;
        e_next         = e_reg;
        k_next         = k_reg;
        lnk_next       = lnk_reg;
        home_path_next = home_path_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_bucket_next  = m_bucket_reg;
        m_status_next  = m_status_reg;
        div_start      = 1'b0;

        wb_we = 1'b0; wb_waddr = len_reg[WL_AW-1:0]; wb_wdata = s_ch;
        wb_raddr = cidx_reg[WL_AW-1:0];
        kc_we = 1'b0;
        kc_waddr = {loaded_reg[KW_AW-1:0], WL_AW'(cidx_reg - 1'b1)};
        kc_wdata = wb_rdata;
        kc_raddr = {k_reg, cidx_reg[WL_AW-1:0]};
        ln_we = 1'b0; ln_waddr = loaded_reg[KW_AW-1:0]; ln_wdata = len_reg;
        ln_raddr = sk_rdata;
        hm_we = 1'b0; hm_waddr = loaded_reg[KW_AW-1:0]; hm_wdata = bucket_reg;
        hm_raddr = kidx_reg[KW_AW-1:0];
        rc_we = 1'b0; rc_waddr = e_reg; rc_wdata = 2'b00;
        rc_raddr = SLOT_AW'(bucket_reg);
        sk_we = 1'b0; sk_waddr = e_reg; sk_wdata = kidx_reg[KW_AW-1:0];
        sk_raddr = e_reg;
        sn_we = 1'b0; sn_waddr = e_reg; sn_wdata = {1'b1, SLOT_AW'(0)};
        sn_raddr = e_reg;

        // drain the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes are taken at any time
        if (cfg_valid) begin
            if (cfg_index == kwh_pkg::CFG_KCOUNT) begin
                kcount_next = cfg_data;
            end else if (cfg_index == kwh_pkg::CFG_CIGN) begin
                cign_next = cfg_data[0];
            end
        end

        case (state_reg)
            S_CLR: begin
                // clear real/used marks, one slot per cycle
                rc_we    = 1'b1;
                rc_waddr = sidx_reg[SLOT_AW-1:0];
                if (sidx_reg == SLOT_CW'(kwh_pkg::TABLE_SLOTS - 1)) begin
                    kidx_next  = '0;
                    state_next = build_req_reg ? S_BR : S_IDLE;
                end else begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (s_func == kwh_pkg::FUNC_BUILD) begin
                        hash_next      = '0;
                        len_next       = '0;
                        sidx_next      = '0;
                        build_req_next = 1'b1;
                        state_next     = S_CLR;
                    end else if (s_func == kwh_pkg::FUNC_CLEAR) begin
                        hash_next      = '0;
                        len_next       = '0;
                        sidx_next      = '0;
                        loaded_next    = '0;
                        built_next     = 1'b0;
                        build_req_next = 1'b0;
                        state_next     = S_CLR;
                    end else begin
                        hash_next = hash_new;
                        if (len_reg < LEN_W'(kwh_pkg::MAX_WORD_LEN)) begin
                            wb_we = 1'b1;
                        end
                        if (len_reg <= LEN_W'(kwh_pkg::MAX_WORD_LEN)) begin
                            len_next = len_reg + 1'b1;
                        end
                        if (s_last) begin
                            func_next  = s_func;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    bucket_next = div_rem;
                    state_next  = S_DEC;
                end
            end
            S_DEC: begin
                status_next = kwh_pkg::ST_OK;
                found_next  = 1'b0;
                cidx_next   = '0;
                if (len_reg > LEN_W'(kwh_pkg::MAX_WORD_LEN)) begin
                    status_next = kwh_pkg::ST_TOO_LONG;
                    state_next  = S_OUT;
                end else if (func_reg == kwh_pkg::FUNC_LOAD) begin
                    if (loaded_reg >= KW_CW'(eff_n)) begin
                        status_next = kwh_pkg::ST_FULL;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_LCP;
                    end
                end else if (!built_reg) begin
                    status_next = kwh_pkg::ST_NOT_BUILT;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_QRC;
                end
            end
            S_LCP: begin
                // read word_buf[i], write keyword char i-1
                if (cidx_reg != '0) begin
                    kc_we = 1'b1;
                end
                if (cidx_reg == len_reg) begin
                    ln_we      = 1'b1;
                    hm_we      = 1'b1;
                    state_next = S_LRC;
                end else begin
                    cidx_next = cidx_reg + 1'b1;
                end
            end
            S_LRC: begin
                rc_we       = 1'b1;
                rc_waddr    = SLOT_AW'(bucket_reg);
                rc_wdata    = {1'b1, rc_rdata[0]};
                loaded_next = loaded_reg + 1'b1;
                built_next  = 1'b0;
                state_next  = S_OUT;
            end
            S_QRC: begin
                if (rc_rdata == 2'b11) begin
                    e_next     = SLOT_AW'(bucket_reg);
                    state_next = S_QE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_QE: begin
                state_next = S_QK;
            end
            S_QK: begin
                k_next     = sk_rdata;
                lnk_next   = sn_rdata;
                state_next = S_QL;
            end
            S_QL: begin
                cidx_next = '0;
                if (ln_rdata == len_reg) begin
                    state_next = S_QC;
                end else begin
                    state_next = S_QNX;
                end
            end
            S_QC: begin
                // issue char i, compare char i-1
                if (cidx_reg != '0 && ch_mismatch) begin
                    state_next = S_QNX;
                end else if (cidx_reg == len_reg) begin
                    found_next = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cidx_next = cidx_reg + 1'b1;
                end
            end
            S_QNX: begin
                if (lnk_reg[SLOT_AW]) begin
                    state_next = S_OUT;
                end else begin
                    e_next     = lnk_reg[SLOT_AW-1:0];
                    state_next = S_QE;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = found_reg;
                    m_bucket_next = bucket_reg;
                    m_status_next = status_reg;
                    hash_next     = '0;
                    len_next      = '0;
                    state_next    = S_IDLE;
                end
            end
            S_BR: begin
                // mark every home slot real
                if (kidx_reg == loaded_reg) begin
                    kidx_next  = '0;
                    sidx_next  = '0;
                    state_next = S_BL;
                end else begin
                    state_next = S_BR2;
                end
            end
            S_BR2: begin
                rc_we      = 1'b1;
                rc_waddr   = SLOT_AW'(hm_rdata);
                rc_wdata   = 2'b10;
                kidx_next  = kidx_reg + 1'b1;
                state_next = S_BR;
            end
            S_BL: begin
                if (kidx_reg == loaded_reg) begin
                    built_next     = 1'b1;
                    build_req_next = 1'b0;
                    state_next     = S_IDLE;
                end else begin
                    state_next = S_BH;
                end
            end
            S_BH: begin
                e_next     = SLOT_AW'(hm_rdata);
                rc_raddr   = SLOT_AW'(hm_rdata);
                state_next = S_BU;
            end
            S_BU: begin
                if (!rc_rdata[0]) begin
                    home_path_next = 1'b1;
                    state_next     = S_BP;
                end else begin
                    state_next = S_BW;
                end
            end
            S_BW: begin
                // follow the chain to its end
                if (sn_rdata[SLOT_AW]) begin
                    state_next = S_BF;
                end else begin
                    e_next     = sn_rdata[SLOT_AW-1:0];
                    sn_raddr   = sn_rdata[SLOT_AW-1:0];
                end
            end
            S_BF: begin
                rc_raddr = sidx_reg[SLOT_AW-1:0];
                if (sidx_reg == SLOT_CW'(kwh_pkg::TABLE_SLOTS)) begin
                    // no free slot left: leave unlinked
                    kidx_next  = kidx_reg + 1'b1;
                    state_next = S_BL;
                end else begin
                    state_next = S_BF2;
                end
            end
            S_BF2: begin
                if (rc_rdata != 2'b00) begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = S_BF;
                end else begin
                    sn_we          = 1'b1;
                    sn_wdata       = {1'b0, sidx_reg[SLOT_AW-1:0]};
                    e_next         = sidx_reg[SLOT_AW-1:0];
                    sidx_next      = sidx_reg + 1'b1;
                    home_path_next = 1'b0;
                    state_next     = S_BP;
                end
            end
            S_BP: begin
                rc_we      = 1'b1;
                rc_wdata   = {home_path_reg, 1'b1};
                sk_we      = 1'b1;
                sn_we      = 1'b1;
                kidx_next  = kidx_reg + 1'b1;
                state_next = S_BL;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            hash_reg      <= '0;
            len_reg       <= '0;
            loaded_reg    <= '0;
            built_reg     <= 1'b0;
            kcount_reg    <= CNT_W'(1);
            cign_reg      <= 1'b0;
            build_req_reg <= 1'b0;
            sidx_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            len_reg       <= len_next;
            loaded_reg    <= loaded_next;
            built_reg     <= built_next;
            kcount_reg    <= kcount_next;
            cign_reg      <= cign_next;
            build_req_reg <= build_req_next;
            sidx_reg      <= sidx_next;
            m_valid_reg   <= m_valid_next;
        end
        func_reg      <= func_next;
        bucket_reg    <= bucket_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        cidx_reg      <= cidx_next;
        kidx_reg      <= kidx_next;
        e_reg         <= e_next;
        k_reg         <= k_next;
        lnk_reg       <= lnk_next;
        home_path_reg <= home_path_next;
        m_found_reg   <= m_found_next;
        m_bucket_reg  <= m_bucket_next;
        m_status_reg  <= m_status_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_found   = m_found_reg;
    assign m_bucket  = m_bucket_reg;
    assign m_status  = m_status_reg;

    // ---------------- assertions ----------------
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_found_reg |-> m_status_reg == kwh_pkg::ST_OK)
        else $error("found reported with non-ok status");

    a_loaded_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= KW_CW'(kwh_pkg::KW_CAP))
        else $error("loaded keyword count beyond capacity");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

endmodule

@@ src/kwh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwh_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/kwh_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwh_div: iterative modulo unit
// Restoring division, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module kwh_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [kwh_pkg::HASH_W-1:0]  dividend,
    input  logic [kwh_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [kwh_pkg::BKT_W-1:0]   rem
);

    localparam int STEP_W = $clog2(kwh_pkg::HASH_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [STEP_W-1:0]          cnt_reg, cnt_next;
    logic [kwh_pkg::HASH_W-1:0] q_reg, q_next;
    logic [kwh_pkg::CNT_W-1:0]  r_reg, r_next;
    logic [kwh_pkg::CNT_W-1:0]  d_reg, d_next;
    logic [kwh_pkg::CNT_W:0]    trial;
    logic [kwh_pkg::CNT_W:0]    diff;

    assign trial = {r_reg, q_reg[kwh_pkg::HASH_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when it fits
            q_next   = {q_reg[kwh_pkg::HASH_W-2:0], 1'b0};
            r_next   = (trial >= {1'b0, d_reg}) ? diff[kwh_pkg::CNT_W-1:0]
                                                : trial[kwh_pkg::CNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(kwh_pkg::HASH_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign rem  = r_reg[kwh_pkg::BKT_W-1:0];

endmodule
